// File: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

// File: rtl/blm_pkg.sv
// shared types and constants of the battery level monitor
package blm_pkg;

    localparam int VOLT_W  = 13;
    localparam int INTV_W  = 16;
    localparam int TIMER_W = 17;
    localparam int CNT_W   = 5;
    localparam int PON_W   = 8;
    localparam int ELAP_W  = 10;
    localparam int PCT_W   = 7;
    localparam int NUM_W   = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;
    localparam logic [PCT_W-1:0] BASE_HI  = 7'd20;
    localparam logic [NUM_W-1:0] SCALE_HI = 20'd80;
    localparam logic [NUM_W-1:0] SCALE_LO = 20'd20;

    localparam logic [VOLT_W-1:0] FULL_RST     = 13'd4100;
    localparam logic [VOLT_W-1:0] EMPTY_RST    = 13'd3500;
    localparam logic [VOLT_W-1:0] SHUTDOWN_RST = 13'd3300;
    localparam logic [INTV_W-1:0] SLOW_RST     = 16'd10000;
    localparam logic [INTV_W-1:0] FAST_RST     = 16'd1000;
    localparam logic [PON_W-1:0]  SAMPLES_RST  = 8'd5;

    typedef enum logic {
        OP_TASK  = 1'b0,
        OP_STORE = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL     = 3'd0,
        CFG_EMPTY    = 3'd1,
        CFG_SHUTDOWN = 3'd2,
        CFG_SLOW     = 3'd3,
        CFG_FAST     = 3'd4,
        CFG_SAMPLES  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic accept;
        logic setup;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic skip_div;
    } t_dp_status;

endpackage

// File: rtl/battery_level_monitor_unit.sv
// top level of the battery level monitor
// Each accepted item yields one result. When the percentage needs a divide, an item
// goes from transfer to result register in these steps: the timer and counters
// update at the transfer itself, then a setup step picks the segment and scales the
// voltage, seven restoring divide steps follow (one quotient bit each) and a last step
// loads the output. Items landing above full, at or below shutdown or on a flat segment
// skip the divide steps. The next item is taken as soon as the previous result sits
// in the output register, so the block takes no new item while one is in flight;
// a stalled output holds the block at most until it drains.
// Configuration writes are always ready and can change the result of an item in flight.
`include "assert_macros.svh"

module battery_level_monitor_unit #(
    parameter int EMPTY_LIMIT    = 10,
    parameter int CRITICAL_LIMIT = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_opcode,
    input  logic [blm_pkg::ELAP_W-1:0]         i_elapsed_ms,
    input  logic [blm_pkg::VOLT_W-1:0]         i_voltage_sample_mv,
    input  logic                               i_link_connected,
    input  logic                               i_backlight_on,
    input  logic                               i_usb_powered,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [blm_pkg::PCT_W-1:0]          o_charge_percent,
    output logic                               o_battery_empty,
    output logic                               o_battery_critical,
    output logic                               o_shutdown_request,
    output logic                               o_measure_request,
    output logic                               o_power_on_sampling,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [blm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [blm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    blm_pkg::t_dp_cmd    cmd;
    blm_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    blm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    blm_dp #(
        .EMPTY_LIMIT    (EMPTY_LIMIT),
        .CRITICAL_LIMIT (CRITICAL_LIMIT)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_opcode            (i_opcode),
        .i_elapsed_ms        (i_elapsed_ms),
        .i_voltage_sample_mv (i_voltage_sample_mv),
        .i_link_connected    (i_link_connected),
        .i_backlight_on      (i_backlight_on),
        .i_usb_powered       (i_usb_powered),
        .i_cfg_write         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_cmd               (cmd),
        .o_status            (status),
        .o_charge_percent    (o_charge_percent),
        .o_battery_empty     (o_battery_empty),
        .o_battery_critical  (o_battery_critical),
        .o_shutdown_request  (o_shutdown_request),
        .o_measure_request   (o_measure_request),
        .o_power_on_sampling (o_power_on_sampling)
    );

    `ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input taken again before result built")
    `ASSERT_IMPLIES(a_pct_range, i_clk, i_rst_n, o_out_valid, o_charge_percent <= blm_pkg::PCT_FULL, "charge percent above full")
    `ASSERT_IMPLIES(a_shutdown_on_check, i_clk, i_rst_n, o_out_valid && o_shutdown_request, o_measure_request, "shutdown without a check")

endmodule

// File: rtl/blm_ctrl.sv
// controller state machine of the battery level monitor
module blm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  blm_pkg::t_dp_status i_status,
    output blm_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SETUP = 4'b0010,
        S_DIV   = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    localparam logic [2:0] LAST_STEP = 3'(blm_pkg::PCT_W - 1);

    t_state     r_state, n_state;
    logic [2:0] r_step,  n_step;
    logic       r_out_valid, n_out_valid;
    logic       slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_step      = '0;
                n_state     = i_status.skip_div ? S_DONE : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 3'd1;
                if (r_step == LAST_STEP) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the output register to drain
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/blm_dp.sv
// datapath of the battery level monitor: state, config, percentage divider
module blm_dp #(
    parameter int EMPTY_LIMIT    = 10,
    parameter int CRITICAL_LIMIT = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_opcode,
    input  logic [blm_pkg::ELAP_W-1:0]         i_elapsed_ms,
    input  logic [blm_pkg::VOLT_W-1:0]         i_voltage_sample_mv,
    input  logic                               i_link_connected,
    input  logic                               i_backlight_on,
    input  logic                               i_usb_powered,
    input  logic                               i_cfg_write,
    input  logic [blm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [blm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  blm_pkg::t_dp_cmd                   i_cmd,
    output blm_pkg::t_dp_status                o_status,
    output logic [blm_pkg::PCT_W-1:0]          o_charge_percent,
    output logic                               o_battery_empty,
    output logic                               o_battery_critical,
    output logic                               o_shutdown_request,
    output logic                               o_measure_request,
    output logic                               o_power_on_sampling
);

    localparam logic [blm_pkg::CNT_W-1:0] E_LIM = blm_pkg::CNT_W'(EMPTY_LIMIT);
    localparam logic [blm_pkg::CNT_W-1:0] C_LIM = blm_pkg::CNT_W'(CRITICAL_LIMIT);
    localparam int DSH_W = blm_pkg::VOLT_W + blm_pkg::PCT_W - 1;

    // configuration
    logic [blm_pkg::VOLT_W-1:0] r_full_mv, r_empty_mv, r_shutdown_mv;
    logic [blm_pkg::INTV_W-1:0] r_slow_ms, r_fast_ms;
    logic [blm_pkg::PON_W-1:0]  r_samples;

    // monitor state
    logic [blm_pkg::VOLT_W-1:0]  r_voltage;
    logic [blm_pkg::TIMER_W-1:0] r_timer;
    logic [blm_pkg::CNT_W-1:0]   r_empty_cnt, r_crit_cnt;
    logic [blm_pkg::PON_W-1:0]   r_pon_cnt;
    logic                        r_shutdown_pulse, r_measure_pulse;

    // divider
    logic [blm_pkg::NUM_W-1:0] r_rem;
    logic [DSH_W-1:0]          r_dsh;
    logic [blm_pkg::PCT_W-1:0] r_quot, r_offset;

    // task step next state
    logic [blm_pkg::TIMER_W:0]   timer_sum;
    logic [blm_pkg::TIMER_W-1:0] timer_sat;
    logic                        sampling, fast_hit, slow_hit, check;
    logic                        e_inc, e_hit;
    logic [blm_pkg::CNT_W-1:0]   n_empty_cnt, n_crit_cnt;
    logic                        n_shutdown_pulse;
    logic [blm_pkg::PON_W-1:0]   pon_base, n_pon_cnt;
    logic [blm_pkg::PON_W:0]     pon_inc;

    always_comb begin
        timer_sum = {1'b0, r_timer} + (blm_pkg::TIMER_W + 1)'(i_elapsed_ms);
        timer_sat = timer_sum[blm_pkg::TIMER_W] ? '1 : timer_sum[blm_pkg::TIMER_W-1:0];
        sampling  = r_pon_cnt < r_samples;
        fast_hit  = sampling && !i_backlight_on
                    && (timer_sat > blm_pkg::TIMER_W'(r_fast_ms));
        slow_hit  = timer_sat > blm_pkg::TIMER_W'(r_slow_ms);
        check     = i_link_connected && (fast_hit || slow_hit);

        e_inc       = check && (r_voltage < r_empty_mv) && (r_empty_cnt <= E_LIM);
        e_hit       = e_inc && (r_empty_cnt == E_LIM);
        n_empty_cnt = e_inc ? r_empty_cnt + 1'b1 : r_empty_cnt;

        n_crit_cnt       = r_crit_cnt;
        n_shutdown_pulse = 1'b0;
        if (check && (r_crit_cnt <= C_LIM)) begin
            if (r_voltage < r_shutdown_mv) begin
                n_crit_cnt       = r_crit_cnt + 1'b1;
                n_shutdown_pulse = (r_crit_cnt == C_LIM);
            end else begin
                n_crit_cnt = '0;
            end
        end

        // crossing the empty limit ends fast sampling
        pon_base = e_hit ? r_samples : r_pon_cnt;
        pon_inc  = {1'b0, pon_base} + 1'b1;
        n_pon_cnt = r_pon_cnt;
        if (check) begin
            n_pon_cnt = (pon_inc > {1'b0, r_samples}) ? r_samples
                                                      : pon_inc[blm_pkg::PON_W-1:0];
        end

        if (i_usb_powered) begin
            n_empty_cnt = '0;
            n_crit_cnt  = '0;
        end
    end

    // percentage segment selection
    logic                      skip_div;
    logic [blm_pkg::PCT_W-1:0] direct_pct, seg_offset;
    logic [blm_pkg::VOLT_W-1:0] seg_span, seg_diff;
    logic [blm_pkg::NUM_W-1:0]  seg_scale;

    always_comb begin
        skip_div   = 1'b1;
        direct_pct = blm_pkg::PCT_ZERO;
        seg_offset = blm_pkg::PCT_ZERO;
        seg_span   = r_full_mv - r_empty_mv;
        seg_diff   = r_voltage - r_empty_mv;
        seg_scale  = blm_pkg::SCALE_HI;
        if (r_voltage > r_full_mv) begin
            direct_pct = blm_pkg::PCT_FULL;
        end else if (r_voltage > r_empty_mv) begin
            if (r_full_mv > r_empty_mv) begin
                skip_div   = 1'b0;
                seg_offset = blm_pkg::BASE_HI;
            end
        end else if (r_voltage > r_shutdown_mv) begin
            seg_span  = r_empty_mv - r_shutdown_mv;
            seg_diff  = r_voltage - r_shutdown_mv;
            seg_scale = blm_pkg::SCALE_LO;
            skip_div  = !(r_empty_mv > r_shutdown_mv);
        end
    end

    assign o_status.skip_div = skip_div;

    logic                      div_ge;
    logic [blm_pkg::NUM_W-1:0] dsh_ext;

    assign dsh_ext = blm_pkg::NUM_W'(r_dsh);
    assign div_ge  = r_rem >= dsh_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_mv     <= blm_pkg::FULL_RST;
            r_empty_mv    <= blm_pkg::EMPTY_RST;
            r_shutdown_mv <= blm_pkg::SHUTDOWN_RST;
            r_slow_ms     <= blm_pkg::SLOW_RST;
            r_fast_ms     <= blm_pkg::FAST_RST;
            r_samples     <= blm_pkg::SAMPLES_RST;
        end else if (i_cfg_write) begin
            case (i_cfg_index)
                blm_pkg::CFG_FULL:     r_full_mv     <= i_cfg_data[blm_pkg::VOLT_W-1:0];
                blm_pkg::CFG_EMPTY:    r_empty_mv    <= i_cfg_data[blm_pkg::VOLT_W-1:0];
                blm_pkg::CFG_SHUTDOWN: r_shutdown_mv <= i_cfg_data[blm_pkg::VOLT_W-1:0];
                blm_pkg::CFG_SLOW:     r_slow_ms     <= i_cfg_data;
                blm_pkg::CFG_FAST:     r_fast_ms     <= i_cfg_data;
                blm_pkg::CFG_SAMPLES:  r_samples     <= i_cfg_data[blm_pkg::PON_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voltage        <= blm_pkg::FULL_RST;
            r_timer          <= '0;
            r_empty_cnt      <= '0;
            r_crit_cnt       <= '0;
            r_pon_cnt        <= '0;
            r_shutdown_pulse <= 1'b0;
            r_measure_pulse  <= 1'b0;
        end else if (i_cmd.accept) begin
            if (i_opcode == blm_pkg::OP_STORE) begin
                r_voltage        <= i_voltage_sample_mv;
                r_shutdown_pulse <= 1'b0;
                r_measure_pulse  <= 1'b0;
            end else begin
                r_timer          <= check ? '0 : timer_sat;
                r_empty_cnt      <= n_empty_cnt;
                r_crit_cnt       <= n_crit_cnt;
                r_pon_cnt        <= n_pon_cnt;
                r_shutdown_pulse <= n_shutdown_pulse;
                r_measure_pulse  <= check;
            end
        end
    end

    // restoring divide, one quotient bit per cycle, msb first
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_rem    <= blm_pkg::NUM_W'(seg_diff) * seg_scale;
            r_dsh    <= {seg_span, (blm_pkg::PCT_W - 1)'(0)};
            r_quot   <= direct_pct;
            r_offset <= seg_offset;
        end else if (i_cmd.div_step) begin
            if (div_ge) begin
                r_rem <= r_rem - dsh_ext;
            end
            r_dsh  <= r_dsh >> 1;
            r_quot <= {r_quot[blm_pkg::PCT_W-2:0], div_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_charge_percent    <= r_quot + r_offset;
            o_battery_empty     <= r_empty_cnt > E_LIM;
            o_battery_critical  <= r_crit_cnt > C_LIM;
            o_shutdown_request  <= r_shutdown_pulse;
            o_measure_request   <= r_measure_pulse;
            o_power_on_sampling <= r_pon_cnt < r_samples;
        end
    end

endmodule
